### hw/rtl/rsp_pkg.sv
// Package: shared types and constants for the rule schedule picker.
`default_nettype none
package rsp_pkg;

  localparam logic [63:0] XS_MUL = 64'd2685821657736338717;

  typedef enum logic [1:0] {
    MODE_CYCLE   = 2'd0,
    MODE_RANDOM  = 2'd1,
    MODE_SHUFFLE = 2'd2,
    MODE_HOLD    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_SEED     = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] rule_value;
  } in_word_t;

  typedef struct packed {
    logic [5:0] current_position;
    logic [7:0] current_rule;
    logic [6:0] rule_count;
    logic       accepted;
    logic       advanced;
  } out_word_t;

endpackage
`default_nettype wire

### hw/rtl/rsp_mod_unit.sv
// Module: shared draw-modulo unit, one quotient bit per cycle (restoring).
`default_nettype none
module rsp_mod_unit
  import rsp_pkg::*;
#(
  parameter int DBITS = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [63:0]      dividend,
  input  wire logic [DBITS-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DBITS-1:0]      remainder
);

  logic [63:0]    shreg;
  logic [DBITS:0] rem;
  logic [6:0]     cnt;
  logic [DBITS:0] trial;

  assign trial = {rem[DBITS-1:0], shreg[63]};
  assign remainder = rem[DBITS-1:0];

  // One bit of the dividend shifted in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 7'd0;
        shreg <= dividend;
        rem   <= '0;
      end else if (busy) begin
        shreg <= {shreg[62:0], 1'b0};
        if (trial >= {1'b0, divisor}) rem <= trial - {1'b0, divisor};
        else rem <= trial;
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rule_schedule_picker.sv
// Top level: rule table, tick scheduler, xorshift64* generator and sequencer.
//
// An append, or a tick that needs no draw, keeps busy high from the accept
// edge through the states TICK, READ, READ2 and OUT, the last of them being
// the one-cycle result strobe done. A random pick adds a draw (xorshift,
// three 32x32 partial products, sum), a state that starts the modulo and the
// bit-serial modulo. A reshuffle after the last entry of a shuffled pass runs
// count - 1 swaps, each a draw and a modulo on the shared modulo unit and
// then read, read, write, write on the single-port table. busy is high from
// the accept edge through the done cycle; results cannot be stalled by the
// receiver. No clearing pass is needed after reset.
`default_nettype none
module rule_schedule_picker
  import rsp_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int RULE_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire in_word_t   in_word,
  output logic            busy,
  output logic            done,
  output out_word_t       out_word,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_DRAW_XS, S_DRAW_MUL, S_DRAW_SUM, S_MOD_GO, S_MOD_WAIT,
    S_SW_RD_A, S_SW_RD_B, S_SW_WR_A, S_SW_WR_B, S_READ, S_READ2, S_OUT
  } state_t;

  state_t state, state_next;

  logic [RULE_BITS-1:0] mem [CAPACITY];
  logic [RULE_BITS-1:0] rd_data;
  logic [AW-1:0]        rd_addr;

  logic [CW-1:0] rule_total;
  logic [AW-1:0] position;
  logic [15:0]   tick_count;
  logic [63:0]   gen_state;
  mode_t         pick_mode;
  logic [15:0]   tick_interval;

  in_word_t      item;
  logic          accepted, advanced, shuffling;
  logic [CW-1:0] sh_i;
  logic [AW-1:0] sh_j;
  logic [RULE_BITS-1:0] val_a;
  logic [63:0]   draw_val;
  logic [31:0]   p_ll, p_lh, p_hl;
  logic [63:0]   xs;

  logic          mod_start;
  logic          mod_busy;
  logic          mod_done;
  logic [CW-1:0] mod_div;
  logic [CW-1:0] mod_rem;

  // xorshift step
  always_comb begin
    xs = gen_state ^ (gen_state >> 12);
    xs = xs ^ (xs << 25);
    xs = xs ^ (xs >> 27);
  end

  assign mod_div   = shuffling ? sh_i : rule_total;
  assign cfg_ready = (state == S_IDLE) && !start;
  assign busy      = (state != S_IDLE);

  rsp_mod_unit #(.DBITS(CW)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(draw_val),
    .divisor(mod_div), .busy(mod_busy), .done(mod_done), .remainder(mod_rem)
  );

  // Single-port table with registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (state == S_TICK && item.operation == OP_APPEND && rule_total < CW'(CAPACITY))
      mem[rule_total[AW-1:0]] <= RULE_BITS'(item.rule_value);
    else if (state == S_SW_WR_A)
      mem[sh_i[AW-1:0] - AW'(1)] <= rd_data;
    else if (state == S_SW_WR_B)
      mem[sh_j] <= val_a;
  end

  always_comb begin
    rd_addr = position;
    if (state == S_SW_RD_A) rd_addr = sh_i[AW-1:0] - AW'(1);
    else if (state == S_SW_RD_B) rd_addr = sh_j;
  end

  // Next state
  always_comb begin
    state_next = state;
    mod_start  = 1'b0;
    unique case (state)
      S_IDLE:     if (start) state_next = S_TICK;
      S_TICK: begin
        state_next = S_READ;
        if (item.operation == OP_TICK && rule_total != '0 &&
            ({1'b0, tick_count} + 17'd1 >= {1'b0, tick_interval})) begin
          if (pick_mode == MODE_RANDOM) state_next = S_DRAW_XS;
          else if (pick_mode == MODE_SHUFFLE &&
                   (CW+1)'(position) + (CW+1)'(1) >= {1'b0, rule_total} &&
                   rule_total > CW'(1)) state_next = S_DRAW_XS;
        end
      end
      S_DRAW_XS:  state_next = S_DRAW_MUL;
      S_DRAW_MUL: state_next = S_DRAW_SUM;
      S_DRAW_SUM: state_next = S_MOD_GO;
      S_MOD_GO: begin
        mod_start  = 1'b1;
        state_next = S_MOD_WAIT;
      end
      S_MOD_WAIT: if (mod_done) state_next = shuffling ? S_SW_RD_A : S_READ;
      S_SW_RD_A:  state_next = S_SW_RD_B;
      S_SW_RD_B:  state_next = S_SW_WR_A;
      S_SW_WR_A:  state_next = S_SW_WR_B;
      S_SW_WR_B:  state_next = (sh_i > CW'(2)) ? S_DRAW_XS : S_READ;
      S_READ:     state_next = S_READ2;
      S_READ2:    state_next = S_OUT;
      S_OUT:      state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Datapath and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_total    <= '0;
      position      <= '0;
      tick_count    <= '0;
      gen_state     <= 64'd1;
      pick_mode     <= MODE_CYCLE;
      tick_interval <= 16'd1;
      shuffling     <= 1'b0;
      accepted      <= 1'b0;
      advanced      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_MODE:     pick_mode <= mode_t'(cfg_data[1:0]);
          REG_INTERVAL: tick_interval <= cfg_data[15:0];
          REG_SEED:     gen_state <= cfg_data;
          REG_NONE:     ;
          default:      ;
        endcase
      end
      unique case (state)
        S_IDLE: if (start) item <= in_word;
        S_TICK: begin
          accepted  <= 1'b0;
          advanced  <= 1'b0;
          shuffling <= 1'b0;
          if (item.operation == OP_APPEND) begin
            if (rule_total < CW'(CAPACITY)) begin
              rule_total <= rule_total + CW'(1);
              accepted   <= 1'b1;
            end
          end else if (rule_total != '0) begin
            if ({1'b0, tick_count} + 17'd1 < {1'b0, tick_interval}) begin
              tick_count <= tick_count + 16'd1;
            end else begin
              tick_count <= '0;
              advanced   <= (pick_mode != MODE_HOLD);
              if (pick_mode == MODE_CYCLE) begin
                if ((CW+1)'(position) + (CW+1)'(1) >= {1'b0, rule_total}) position <= '0;
                else position <= position + AW'(1);
              end else if (pick_mode == MODE_SHUFFLE) begin
                if ((CW+1)'(position) + (CW+1)'(1) >= {1'b0, rule_total}) begin
                  position  <= '0;
                  shuffling <= (rule_total > CW'(1));
                  sh_i      <= rule_total;
                end else begin
                  position <= position + AW'(1);
                end
              end
            end
          end
        end
        S_DRAW_XS:  gen_state <= xs;
        S_DRAW_MUL: begin
          {p_hl, p_ll} <= gen_state[31:0] * XS_MUL[31:0];
          p_lh <= 32'(gen_state[31:0] * XS_MUL[63:32]);
          draw_val <= {32'(gen_state[63:32] * XS_MUL[31:0]), 32'd0};
        end
        S_DRAW_SUM: draw_val <= {p_hl, p_ll} + {p_lh, 32'd0} + draw_val;
        S_MOD_WAIT: if (mod_done) begin
          if (shuffling) sh_j <= mod_rem[AW-1:0];
          else position <= mod_rem[AW-1:0];
        end
        S_SW_RD_B:  val_a <= rd_data;
        S_SW_WR_B:  begin
          sh_i <= sh_i - CW'(1);
          if (sh_i <= CW'(2)) shuffling <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Result strobe
  assign done = (state == S_OUT);
  always_comb begin
    out_word.current_position = 6'(position);
    out_word.current_rule     = (rule_total != '0) ? 8'(rd_data) : 8'd0;
    out_word.rule_count       = 7'(rule_total);
    out_word.accepted         = accepted;
    out_word.advanced         = advanced;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rule_total <= CW'(CAPACITY)) else $error("rule count above capacity");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && rule_total != '0) |-> ({1'b0, position} < {1'b0, rule_total}))
    else $error("position outside table");
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_mod_idle: assert property (@(posedge clk) disable iff (rst)
    mod_start |-> !mod_busy) else $error("modulo unit restarted while busy");

endmodule
`default_nettype wire
